@@ src/assert_macros.svh @@
// Assertion macros shared by the deque RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside of reset.
`define DEQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define DEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEQ_ASSERT(label, clk, rst, prop, msg)
`define DEQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ src/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package deq_pkg;

   // Default geometry.
   localparam int DEQ_DEPTH      = 16;
   localparam int DEQ_DATA_WIDTH = 32;

   // Fixed field widths of the request and response words.
   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // Command codes; the two unused codes are ignored.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_CLEAR      = 3'd5
   } deq_cmd_type;

   // Per-cycle operation broadcast to every cell of the row.
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop_front;
      logic pop_back;
      logic clear;
   } deq_ctrl_type;

endpackage

@@ src/deq_ifs.sv @@
// Request and response channel interfaces of the double-ended queue.
interface deq_req_if import deq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] push_value;

   modport source (output valid, command, push_value, input ready);
   modport sink   (input valid, command, push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [VALUE_W-1:0] out_value;
   logic [COUNT_W-1:0] count;

   modport source (output valid, ok, out_value, count, input ready);
   modport sink   (input valid, ok, out_value, count, output ready);
endinterface

@@ src/deq_cell.sv @@
// One storage cell of the deque row: a word plus its occupied bit.
module deq_cell import deq_pkg::*; #(
   parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_ctrl_type          ctrl,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic                  left_valid,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic                  right_valid,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  valid,
   output logic                  is_back
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;

   // Next word and occupied bit: clear, shift toward the back, shift toward the front, or fill/free at the back
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.push_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.pop_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.push_back) begin
         // first free cell takes the word
         if (!valid_ff && left_valid) begin
            data_in  = push_data;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_back) begin
         // last occupied cell lets go
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   // Occupied bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stored word, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign valid   = valid_ff;
   assign is_back = valid_ff && !right_valid;

endmodule

@@ src/deq_chain.sv @@
// Row of deque cells with the front word at cell 0 and back-word select.
`include "assert_macros.svh"
module deq_chain import deq_pkg::*; #(
   parameter int DEPTH      = DEQ_DEPTH,
   parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_ctrl_type          ctrl,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic [DATA_WIDTH-1:0] front_word,
   output logic [DATA_WIDTH-1:0] back_word
);

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      cell_back;

   // Cells wired to their neighbors; the ends see the push word or an empty cell
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      logic                  left_valid, right_valid;

      if (i == 0) begin : g_first
         assign left_data  = push_data;
         assign left_valid = 1'b1;
      end else begin : g_mid_l
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid_r
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      deq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_data   (push_data),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .is_back     (cell_back[i])
      );
   end

   // Back word: at most one cell flags itself as the back, AND-OR select
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | (cell_back[i] ? cell_data[i] : '0);
      end
   end

   assign front_word = cell_data[0];

   // Occupied cells always form one run starting at cell 0
   `DEQ_ASSERT(a_valid_contiguous, clock, reset,
      $onehot({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}), "occupied cells not contiguous")
   `DEQ_ASSERT(a_one_back, clock, reset, $onehot0(cell_back), "more than one back cell")

endmodule

@@ src/double_ended_queue.sv @@
// Double-ended queue top level: command decode, fill count, response register.
// The response word for an accepted command is registered. Throughput: one command per
// cycle while responses are taken; every cell of the row updates in the accepting cycle.
// A new command is taken while a response waits only if that response is taken too.
// Reset clears the fill count, all occupied bits and the response valid; stored words
// are not cleared and are never read before a push writes them.
`include "assert_macros.svh"
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH      = DEQ_DEPTH,
   parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);

   localparam int FILL_W = $clog2(DEPTH + 1);

   deq_cmd_type           cmd;
   deq_ctrl_type          ctrl_raw, ctrl;
   logic                  req_fire;
   logic                  full, empty;
   logic                  ok;
   logic [DATA_WIDTH-1:0] word;
   logic [DATA_WIDTH-1:0] push_data;
   logic [DATA_WIDTH-1:0] front_word, back_word;

   logic [FILL_W-1:0]     fill_ff, fill_in, fill_next;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign cmd       = deq_cmd_type'(req_chan.command);
   assign push_data = DATA_WIDTH'(req_chan.push_value);
   assign full      = (fill_ff == FILL_W'(DEPTH));
   assign empty     = (fill_ff == '0);

   // Command decode: cell operation, result flag, word and new count
   always_comb begin
      ctrl_raw  = '0;
      ok        = 1'b0;
      word      = '0;
      fill_next = fill_ff;
      unique case (cmd)
         CMD_PUSH_BACK: begin
            if (!full) begin
               ctrl_raw.push_back = 1'b1;
               ok        = 1'b1;
               fill_next = fill_ff + FILL_W'(1);
            end
         end
         CMD_PUSH_FRONT: begin
            if (!full) begin
               ctrl_raw.push_front = 1'b1;
               ok        = 1'b1;
               fill_next = fill_ff + FILL_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (!empty) begin
               ctrl_raw.pop_front = 1'b1;
               ok        = 1'b1;
               word      = front_word;
               fill_next = fill_ff - FILL_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (!empty) begin
               ctrl_raw.pop_back = 1'b1;
               ok        = 1'b1;
               word      = back_word;
               fill_next = fill_ff - FILL_W'(1);
            end
         end
         CMD_PEEK_FRONT: begin
            if (!empty) begin
               ok   = 1'b1;
               word = front_word;
            end
         end
         CMD_CLEAR: begin
            ctrl_raw.clear = 1'b1;
            ok        = 1'b1;
            fill_next = '0;
         end
         default: begin
            // unused codes: no change, ok low
         end
      endcase
   end

   assign ctrl    = req_fire ? ctrl_raw : '0;
   assign fill_in = req_fire ? fill_next : fill_ff;

   // Cell row
   deq_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .push_data  (push_data),
      .front_word (front_word),
      .back_word  (back_word)
   );

   // Response word next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok;
         rsp_value_in = VALUE_W'(word);
         rsp_count_in = COUNT_W'(fill_next);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers
   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.ok        = rsp_ok_ff;
   assign rsp_chan.out_value = rsp_value_ff;
   assign rsp_chan.count     = rsp_count_ff;

   `DEQ_ASSERT(a_fill_bound, clock, reset, fill_ff <= FILL_W'(DEPTH), "fill above depth")
   `DEQ_ASSERT(a_clear_empties, clock, reset,
      req_fire && (cmd == CMD_CLEAR) |=> (fill_ff == '0), "clear left words")
   `DEQ_ASSERT(a_full_push_holds, clock, reset,
      req_fire && full && ((cmd == CMD_PUSH_BACK) || (cmd == CMD_PUSH_FRONT)) |=>
      $stable(fill_ff) && !rsp_ok_ff, "push on full changed the queue")

endmodule
